[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RBRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define RBRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/rbrc_pkg.sv]
`timescale 1ns / 1ps
package rbrc_pkg;

  localparam int MaxZones = 64;
  localparam int IdxW     = $clog2(MaxZones);
  localparam int CntW     = IdxW + 1;
  localparam int BlkW     = 48;
  localparam int EndW     = BlkW + 1;
  localparam int NumW     = 32;

  // request type codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // configuration register indexes
  localparam logic CFG_FIRST_DATA = 1'b0;
  localparam logic CFG_TOTAL      = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [BlkW-1:0] start_block;
    logic [NumW-1:0] block_count;
  } req_t;

  typedef struct packed {
    logic            range_valid;
    logic            table_full;
    logic [BlkW-1:0] error_block;
  } res_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_ADJ,
    OP_EXT,
    OP_INS,
    OP_MRG
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [CntW-1:0] pos;
    logic [CntW-1:0] used;
    logic [BlkW-1:0] s;
    logic [EndW-1:0] e;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic le;
    logic ovl;
    logic adj;
  } cell_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_ADJ1,
    S_PRE,
    S_ADJ2,
    S_SUC
  } state_e;

  // lowest set bit index, MaxZones when none is set
  function automatic logic [CntW-1:0] first_set(input logic [MaxZones-1:0] v);
    logic [CntW-1:0] r;
    r = CntW'(MaxZones);
    for (int k = MaxZones - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = CntW'(k);
      end
    end
    return r;
  endfunction

endpackage

[sv/reserved_block_range_checker_core.sv]
`timescale 1ns / 1ps
// Reserved block range checker. A transaction is taken when start is high while busy is
// low. A check runs a compare, in which all cells compare against the request in parallel,
// and a decide step, then strobes done_o. An add that fails on a full table ends the same
// way; any other add runs compare, extend or insert with a one-step shift along the cell
// row, then a neighbor compare and an optional merge shift for each side. The result
// is held on res_o for the single cycle that done_o is high; it must be taken then, since
// there is no backpressure. The next transaction may start in that cycle.
module reserved_block_range_checker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  rbrc_pkg::req_t            req_i,
  output logic                      done_o,
  output rbrc_pkg::res_t            res_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rbrc_pkg::BlkW-1:0] cfg_data_i
);
  import rbrc_pkg::*;
  `include "assert_macros.svh"

  state_e          state_q, state_d;
  req_t            req_q;
  logic [BlkW-1:0] first_q, total_q;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [BlkW-1:0] bad_q, bad_d;
  res_t            res_q, res_d;
  logic            done_q, done_d;
  cell_cmd_t       cmd;

  logic [BlkW-1:0]     c_start [MaxZones];
  logic [EndW-1:0]     c_end   [MaxZones];
  cell_flags_t         c_flags [MaxZones];
  logic [MaxZones-1:0] hit_v, le_v, ovl_v, adj_v;

  logic [EndW-1:0] req_end;
  logic [CntW-1:0] hit_pos, ins_pos;
  logic            found, room, bad_bounds, pre_mrg, suc_mrg;
  logic [IdxW-1:0] pos_idx;

  assign req_end    = {1'b0, req_q.start_block} + EndW'(req_q.block_count);
  assign hit_pos    = first_set(hit_v);
  assign ins_pos    = first_set(~le_v);
  assign found      = |hit_v;
  assign room       = used_q < CntW'(MaxZones);
  assign bad_bounds = (req_q.start_block <= first_q) || (req_end > {1'b0, total_q});
  assign pos_idx    = pos_q[IdxW-1:0];
  assign pre_mrg    = (pos_q != '0) && adj_v[pos_idx - 1'b1];
  assign suc_mrg    = ((pos_q + 1'b1) < used_q) && adj_v[pos_idx];

  // row of cells
  for (genvar k = 0; k < MaxZones; k++) begin : g_cell
    logic [BlkW-1:0] ps, ns;
    logic [EndW-1:0] pe, ne;
    if (k == 0) begin : g_first
      assign ps = '0;
      assign pe = '0;
    end else begin : g_mid
      assign ps = c_start[k-1];
      assign pe = c_end[k-1];
    end
    if (k == MaxZones - 1) begin : g_last
      assign ns = '0;
      assign ne = '0;
    end else begin : g_body
      assign ns = c_start[k+1];
      assign ne = c_end[k+1];
    end
    rbrc_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IdxW'(k)),
      .cmd_i        (cmd),
      .prev_start_i (ps),
      .prev_end_i   (pe),
      .next_start_i (ns),
      .next_end_i   (ne),
      .start_o      (c_start[k]),
      .end_o        (c_end[k]),
      .flags_o      (c_flags[k])
    );
    assign hit_v[k] = c_flags[k].hit;
    assign le_v[k]  = c_flags[k].le;
    assign ovl_v[k] = c_flags[k].ovl;
    assign adj_v[k] = c_flags[k].adj;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_CMP;
      S_CMP:  state_d = S_DEC;
      S_DEC: begin
        if (req_q.req_type == REQ_CHECK || (!found && !room)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_ADJ1;
        end
      end
      S_ADJ1: state_d = S_PRE;
      S_PRE:  state_d = S_ADJ2;
      S_ADJ2: state_d = S_SUC;
      S_SUC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // cell commands and bookkeeping
  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.pos  = pos_q;
    cmd.used = used_q;
    cmd.s    = req_q.start_block;
    cmd.e    = req_end;
    pos_d    = pos_q;
    used_d   = used_q;
    bad_d    = bad_q;
    res_d    = res_q;
    done_d   = 1'b0;
    unique case (state_q)
      S_CMP: cmd.op = OP_CMP;
      S_DEC: begin
        if (req_q.req_type == REQ_CHECK) begin
          res_d.range_valid = !(bad_bounds || (|ovl_v));
          res_d.table_full  = 1'b0;
          if (bad_bounds || (|ovl_v)) begin
            bad_d = req_q.start_block;
          end
          res_d.error_block = (bad_bounds || (|ovl_v)) ? req_q.start_block : bad_q;
          done_d = 1'b1;
        end else if (found) begin
          cmd.op  = OP_EXT;
          cmd.pos = hit_pos;
          pos_d   = hit_pos;
        end else if (room) begin
          cmd.op  = OP_INS;
          cmd.pos = ins_pos;
          pos_d   = ins_pos;
          used_d  = used_q + 1'b1;
        end else begin
          res_d.range_valid = 1'b0;
          res_d.table_full  = 1'b1;
          res_d.error_block = bad_q;
          done_d = 1'b1;
        end
      end
      S_ADJ1, S_ADJ2: cmd.op = OP_ADJ;
      S_PRE: begin
        if (pre_mrg) begin
          cmd.op  = OP_MRG;
          cmd.pos = pos_q - 1'b1;
          pos_d   = pos_q - 1'b1;
          used_d  = used_q - 1'b1;
        end
      end
      S_SUC: begin
        if (suc_mrg) begin
          cmd.op = OP_MRG;
          used_d = used_q - 1'b1;
        end
        res_d.range_valid = 1'b1;
        res_d.table_full  = 1'b0;
        res_d.error_block = bad_q;
        done_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      bad_q   <= '0;
      done_q  <= 1'b0;
      first_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      bad_q   <= bad_d;
      done_q  <= done_d;
      if (cfg_we_i && cfg_idx_i == CFG_FIRST_DATA) first_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_TOTAL) total_q <= cfg_data_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

  `RBRC_ASSERT(a_used_range, used_q <= CntW'(MaxZones), "entry count above table size")
  `RBRC_ASSERT_IMP(a_done_idle, done_q, !busy, "result strobe while still working")
  `RBRC_ASSERT_IMP(a_full_only_add, done_q && res_q.table_full,
                   !res_q.range_valid && used_q == CntW'(MaxZones), "bad full report")
  `RBRC_ASSERT_IMP(a_ins_room, cmd.op == OP_INS, room, "insert into full table")

endmodule

[sv/rbrc_cell.sv]
`timescale 1ns / 1ps
module rbrc_cell (
  input  logic                     clk_i,
  input  logic [rbrc_pkg::IdxW-1:0] idx_i,
  input  rbrc_pkg::cell_cmd_t      cmd_i,
  input  logic [rbrc_pkg::BlkW-1:0] prev_start_i,
  input  logic [rbrc_pkg::EndW-1:0] prev_end_i,
  input  logic [rbrc_pkg::BlkW-1:0] next_start_i,
  input  logic [rbrc_pkg::EndW-1:0] next_end_i,
  output logic [rbrc_pkg::BlkW-1:0] start_o,
  output logic [rbrc_pkg::EndW-1:0] end_o,
  output rbrc_pkg::cell_flags_t    flags_o
);
  import rbrc_pkg::*;

  logic [BlkW-1:0] start_q, start_d;
  logic [EndW-1:0] end_q, end_d;
  cell_flags_t     flags_q, flags_d;
  logic            vld;
  logic            at_pos;
  logic            above_pos;
  logic [EndW-1:0] s_ext;

  assign vld       = {1'b0, idx_i} < cmd_i.used;
  assign at_pos    = {1'b0, idx_i} == cmd_i.pos;
  assign above_pos = {1'b0, idx_i} > cmd_i.pos;
  assign s_ext     = {1'b0, cmd_i.s};

  // entry update and compare flags
  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    flags_d = flags_q;
    unique case (cmd_i.op)
      OP_CMP: begin
        flags_d.hit = vld && (s_ext >= {1'b0, start_q}) && (s_ext < end_q);
        flags_d.le  = vld && (start_q <= cmd_i.s);
        flags_d.ovl = vld && (cmd_i.e > {1'b0, start_q}) && (s_ext < end_q);
      end
      OP_ADJ: begin
        flags_d.adj = end_q == {1'b0, next_start_i};
      end
      OP_EXT: begin
        if (at_pos && (cmd_i.e > end_q)) begin
          end_d = cmd_i.e;
        end
      end
      OP_INS: begin
        if (at_pos) begin
          start_d = cmd_i.s;
          end_d   = cmd_i.e;
        end else if (above_pos) begin
          start_d = prev_start_i;
          end_d   = prev_end_i;
        end
      end
      OP_MRG: begin
        if (at_pos) begin
          end_d = next_end_i;
        end else if (above_pos) begin
          start_d = next_start_i;
          end_d   = next_end_i;
        end
      end
      default: begin
      end
    endcase
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    flags_q <= flags_d;
  end

  assign start_o = start_q;
  assign end_o   = end_q;
  assign flags_o = flags_q;

endmodule

[bench/reserved_block_range_checker_core_tb.sv]
`timescale 1ns / 1ps
module reserved_block_range_checker_core_tb;
  import rbrc_pkg::*;

  localparam int WatchLimit = 5000;
  localparam int DrainCycles = 10;
  localparam logic [BlkW-1:0] BlkMax = '1;
  localparam logic [NumW-1:0] NumMax = '1;

  // directed stimulus row, expected result typed only where obvious
  typedef struct {
    req_t rq;
    bit   typed;
    res_t res;
  } stim_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  req_t            req_q;
  logic            done;
  res_t            res_o;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [BlkW-1:0] cfg_data_i;

  // predictor state
  logic [BlkW-1:0] zone_lo [MaxZones];
  logic [EndW-1:0] zone_hi [MaxZones];
  int              zone_cnt;
  logic [BlkW-1:0] bad_blk;
  logic [BlkW-1:0] first_data;
  logic [BlkW-1:0] vol_blocks;

  res_t expected_res_q[$];
  int   errors = 0;
  int   idle_pct;
  int   quiet_cycles = 0;
  stim_row_t rows[$];

  reserved_block_range_checker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_q),
    .done_o     (done),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // remove one zone, closing the gap
  function automatic void zone_drop(input int idx);
    for (int k = idx; k + 1 < zone_cnt; k++) begin
      zone_lo[k] = zone_lo[k + 1];
      zone_hi[k] = zone_hi[k + 1];
    end
    zone_cnt--;
  endfunction

  // reserve a range; returns 0 when a new zone is needed and the table is full
  function automatic bit zone_reserve(input logic [BlkW-1:0] s, input logic [NumW-1:0] cnt);
    logic [EndW-1:0] e;
    int pos;
    bit found;
    e = {1'b0, s} + EndW'(cnt);
    pos = zone_cnt;
    found = 0;
    for (int k = 0; k < zone_cnt; k++) begin
      if (!found && {1'b0, s} >= {1'b0, zone_lo[k]} && {1'b0, s} < zone_hi[k]) begin
        pos = k;
        found = 1;
      end
    end
    if (found) begin
      if (e > zone_hi[pos]) zone_hi[pos] = e;
    end else begin
      if (zone_cnt >= MaxZones) return 0;
      pos = 0;
      while (pos < zone_cnt && zone_lo[pos] <= s) pos++;
      for (int k = zone_cnt; k > pos; k--) begin
        zone_lo[k] = zone_lo[k - 1];
        zone_hi[k] = zone_hi[k - 1];
      end
      zone_lo[pos] = s;
      zone_hi[pos] = e;
      zone_cnt++;
    end
    // merge with exactly adjacent neighbors
    if (pos > 0 && zone_hi[pos - 1] == {1'b0, zone_lo[pos]}) begin
      zone_lo[pos] = zone_lo[pos - 1];
      zone_drop(pos - 1);
      pos--;
    end
    if (pos + 1 < zone_cnt && zone_hi[pos] == {1'b0, zone_lo[pos + 1]}) begin
      zone_hi[pos] = zone_hi[pos + 1];
      zone_drop(pos + 1);
    end
    return 1;
  endfunction

  // free data range test against volume bounds and every zone
  function automatic bit range_free(input logic [BlkW-1:0] s, input logic [NumW-1:0] cnt);
    logic [EndW-1:0] last;
    if (s <= first_data || ({1'b0, s} + EndW'(cnt)) > {1'b0, vol_blocks}) begin
      bad_blk = s;
      return 0;
    end
    last = {1'b0, s} + EndW'(cnt) - 1'b1;
    for (int k = 0; k < zone_cnt; k++) begin
      if (last >= {1'b0, zone_lo[k]} && {1'b0, s} < zone_hi[k]) begin
        bad_blk = s;
        return 0;
      end
    end
    return 1;
  endfunction

  function automatic res_t predict_range(input req_t r);
    res_t o;
    o = '0;
    if (r.req_type == REQ_ADD) begin
      o.range_valid = zone_reserve(r.start_block, r.block_count);
      o.table_full = !o.range_valid;
    end else begin
      o.range_valid = range_free(r.start_block, r.block_count);
    end
    o.error_block = bad_blk;
    return o;
  endfunction

  // drive one transaction; start stays high on return
  task automatic issue(input req_t r, input bit typed, input res_t typed_res);
    res_t p;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    req_q <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = predict_range(r);
    expected_res_q.push_back(typed ? typed_res : p);
  endtask

  // wait until the block has nothing left in flight
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_res_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [BlkW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FIRST_DATA) first_data = val;
    else vol_blocks = val;
  endtask

  function automatic req_t rand_range(input int span);
    req_t r;
    r.req_type = ($urandom_range(99) < 40) ? REQ_ADD : REQ_CHECK;
    if ($urandom_range(99) < 8) begin
      r.start_block = BlkW'({$urandom(), $urandom()});
      r.block_count = $urandom();
    end else begin
      r.start_block = BlkW'($urandom_range(span));
      r.block_count = NumW'($urandom_range(12));
    end
    return r;
  endfunction

  // result checking
  always @(posedge clk_i) begin
    res_t ex;
    if (rst_ni && done) begin
      if (expected_res_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, res_o);
        errors++;
      end else begin
        ex = expected_res_q.pop_front();
        if (res_o.range_valid !== ex.range_valid)
          $display("%0t: range_valid expected %0b actual %0b", $realtime, ex.range_valid,
                   res_o.range_valid);
        if (res_o.table_full !== ex.table_full)
          $display("%0t: table_full expected %0b actual %0b", $realtime, ex.table_full,
                   res_o.table_full);
        if (res_o.error_block !== ex.error_block)
          $display("%0t: error_block expected %0h actual %0h", $realtime, ex.error_block,
                   res_o.error_block);
        if (res_o !== ex) errors++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_t r;
    stim_row_t row;
    rst_ni = 1'b0;
    start = 1'b0;
    req_q = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FIRST_DATA;
    cfg_data_i = '0;
    idle_pct = 0;
    zone_cnt = 0;
    bad_blk = '0;
    first_data = '0;
    vol_blocks = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: every check fails on volume bounds
    row = '{'{REQ_CHECK, 48'd5, 32'd1}, 1, '{1'b0, 1'b0, 48'd5}};
    rows.push_back(row);
    foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].res);
    drain();
    rows.delete();
    cfg_write(CFG_FIRST_DATA, '0);
    cfg_write(CFG_TOTAL, BlkMax);
    row = '{'{REQ_CHECK, 48'd0, 32'd0}, 1, '{1'b0, 1'b0, 48'd0}};

    // directed ranges: extremes, merges, extension, empty ranges, overlap
    rows.push_back(row);
    rows.push_back('{'{REQ_CHECK, BlkMax, NumMax}, 1, '{1'b0, 1'b0, BlkMax}});
    rows.push_back('{'{REQ_CHECK, 48'd1, 32'd0}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd100, 32'd10}, 1, '{1'b1, 1'b0, BlkMax}});
    rows.push_back('{'{REQ_ADD, 48'd110, 32'd5}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd90, 32'd10}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd95, 32'd50}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd200, 32'd0}, 0, '0});
    rows.push_back('{'{REQ_CHECK, 48'd200, 32'd0}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd200, 32'd3}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd160, 32'd60}, 0, '0});
    rows.push_back('{'{REQ_ADD, 48'd150, 32'd2}, 0, '0});
    rows.push_back('{'{REQ_CHECK, 48'd120, 32'd1}, 0, '0});
    rows.push_back('{'{REQ_CHECK, 48'd145, 32'd5}, 0, '0});
    rows.push_back('{'{REQ_CHECK, 48'd300, 32'd5}, 0, '0});
    rows.push_back('{'{REQ_ADD, BlkMax, NumMax}, 0, '0});
    rows.push_back('{'{REQ_CHECK, BlkMax - 48'd1, 32'd1}, 0, '0});
    rows.push_back('{'{REQ_CHECK, 48'hAAAA_AAAA_AAAA, 32'h5555_5555}, 0, '0});
    rows.push_back('{'{REQ_CHECK, 48'h5555_5555_5555, 32'hAAAA_AAAA}, 0, '0});
    foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].res);
    drain();

    // random phases over several register settings and idle rates
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_FIRST_DATA, 48'd10);
          cfg_write(CFG_TOTAL, 48'd600);
          idle_pct = 0;
        end
        1: begin
          cfg_write(CFG_FIRST_DATA, '0);
          cfg_write(CFG_TOTAL, BlkMax);
          idle_pct = 83;
        end
        2: begin
          cfg_write(CFG_FIRST_DATA, BlkW'($urandom_range(40)));
          cfg_write(CFG_TOTAL, BlkW'($urandom_range(700, 300)));
          idle_pct = 23;
        end
        3: begin
          cfg_write(CFG_FIRST_DATA, BlkMax);
          cfg_write(CFG_TOTAL, '0);
          idle_pct = 83;
        end
        default: begin
          cfg_write(CFG_FIRST_DATA, 48'd1);
          cfg_write(CFG_TOTAL, BlkW'(2000));
          idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 95; n++) begin
        r = rand_range(ph == 4 ? 2000 : 600);
        issue(r, 0, '0);
        if (n == 50) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (expected_res_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    // fill the table with spaced ranges until it overflows
    idle_pct = 23;
    for (int n = 0; n < 70; n++) begin
      r.req_type = REQ_ADD;
      r.start_block = BlkW'(100000 + n * 10);
      r.block_count = 32'd2;
      issue(r, 0, '0);
    end
    // extending an existing zone still works when full
    r.start_block = 48'd100000;
    r.block_count = 32'd5;
    issue(r, 0, '0);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[reserved_block_range_checker_core.f]
+incdir+sv
sv/rbrc_pkg.sv
sv/rbrc_cell.sv
sv/reserved_block_range_checker_core.sv
bench/reserved_block_range_checker_core_tb.sv
